@@ hdl/three_axis_sliding_median_defines.svh @@
// Assertion macros for the three-axis sliding median block.
// Used by the top level only; needs nothing else.
`ifndef THREE_AXIS_SLIDING_MEDIAN_DEFINES_SVH
`define THREE_AXIS_SLIDING_MEDIAN_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TASM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TASM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tasm_pkg.sv @@
// Shared types and constants for the three-axis sliding median.
// No dependencies.
package tasm_pkg;

  // Register and count port widths, fixed by the interface.
  localparam int CFG_WIDTH       = 7;
  localparam int COUNT_OUT_WIDTH = 7;
  localparam int WIN_RESET       = 8;
  localparam int NUM_AXES        = 3;

  // Per-cycle control broadcast to every sorting cell.
  typedef struct packed {
    logic load;  // a sample transfer updates the chain this cycle
    logic full;  // window full: drop the oldest value before inserting
  } cell_ctrl_t;

endpackage

@@ hdl/tasm_ram.sv @@
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
module tasm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/tasm_cell.sv @@
// One compare-and-shift cell of a sorted chain (one axis, one rank).
// Depends on tasm_pkg.
module tasm_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_BITS    = 7,
  parameter int INDEX       = 0
) (
  input  logic                          clk,
  input  tasm_pkg::cell_ctrl_t          ctrl,
  input  logic        [CNT_BITS-1:0]    cnt,        // entries kept after removal
  input  logic signed [SAMPLE_BITS-1:0] sample,     // value being inserted
  input  logic signed [SAMPLE_BITS-1:0] old,        // value leaving the window
  input  logic signed [SAMPLE_BITS-1:0] right_val,  // neighbor at rank + 1
  input  logic signed [SAMPLE_BITS-1:0] left_rem,   // neighbor's value after removal
  input  logic                          left_le,    // neighbor stays below sample
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic signed [SAMPLE_BITS-1:0] rem,
  output logic                          le
);

  import tasm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] val_next;

  // Removal closes the gap at the first entry equal to the leaving value.
  assign rem = (ctrl.full && (val >= old)) ? right_val : val;
  // Equal samples: the new one goes after them.
  assign le  = (CNT_BITS'(INDEX) < cnt) && (rem <= sample);

  always_comb begin
    if (le) begin
      val_next = rem;
    end else if (left_le) begin
      val_next = sample;
    end else begin
      val_next = left_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      val <= val_next;
    end
  end

endmodule

@@ hdl/three_axis_sliding_median.sv @@
// Three-axis sliding median: top level.
// Depends on tasm_pkg, tasm_cell, tasm_ram and three_axis_sliding_median_defines.svh.
//
// Keeps the last window_len samples of each axis (x, y, z) and returns, for
// every sample transfer, the median of each axis over the samples held:
// the middle value for an odd count, the floor of the mean of the two middle
// values for an even count, together with the number held (held_count).
// The block takes one sample per clock while in_stall is low; a result passes
// s1 (the chain), s2 and out. Throughput is set by the sorted chain, a row of
// WINDOW_MAX compare-and-shift cells per axis that removes the oldest value
// and inserts the new one in the same cycle. The oldest value comes from an
// arrival-order ring RAM read at ptr_next in the cycle before, with a bypass
// when the same entry was just written (window length one). The ring and
// chain need no clearing after reset: fill tracks which entries are live.
// Writing window_len (0 reads as 1, values above WINDOW_MAX saturate) empties
// the window; write it only while no transfer is in flight. Output stalls
// back up through two buffered stages before in_stall rises.
`include "three_axis_sliding_median_defines.svh"

module three_axis_sliding_median #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_wr_en,
  input  logic        [tasm_pkg::CFG_WIDTH-1:0]       cfg_wr_data,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [SAMPLE_BITS-1:0]               sample_x,
  input  logic signed [SAMPLE_BITS-1:0]               sample_y,
  input  logic signed [SAMPLE_BITS-1:0]               sample_z,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [SAMPLE_BITS-1:0]               median_x,
  output logic signed [SAMPLE_BITS-1:0]               median_y,
  output logic signed [SAMPLE_BITS-1:0]               median_z,
  output logic        [tasm_pkg::COUNT_OUT_WIDTH-1:0] held_count
);

  import tasm_pkg::*;

  localparam int CW = $clog2(WINDOW_MAX + 1);   // count width
  localparam int PW = $clog2(WINDOW_MAX);       // ring / rank index width
  localparam int EW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;
  localparam int RW = NUM_AXES * SAMPLE_BITS;
  localparam logic [CW-1:0] WinReset =
    (WIN_RESET > WINDOW_MAX) ? CW'(WINDOW_MAX) : CW'(WIN_RESET);

  // ---------------------------------------------------------------- window
  logic [CW-1:0] win;          // effective window length
  logic [CW-1:0] win_cfg;
  logic [EW-1:0] cfg_ext;
  logic [CW-1:0] fill, fill_next;
  logic [PW-1:0] ptr, ptr_next; // oldest entry in the ring once full
  logic          full;
  logic          accept;
  logic [CW-1:0] cnt;

  assign cfg_ext = EW'(cfg_wr_data);

  always_comb begin
    if (cfg_ext == '0) begin
      win_cfg = CW'(1);
    end else if (cfg_ext > EW'(WINDOW_MAX)) begin
      win_cfg = CW'(WINDOW_MAX);
    end else begin
      win_cfg = CW'(cfg_ext);
    end
  end

  assign full   = (fill == win);
  assign accept = in_valid && !in_stall;
  assign cnt    = full ? (win - CW'(1)) : fill;

  always_comb begin
    fill_next = fill;
    ptr_next  = ptr;
    if (cfg_wr_en) begin
      fill_next = '0;
      ptr_next  = '0;
    end else if (accept) begin
      if (!full) begin
        fill_next = fill + CW'(1);
      end else if (CW'(ptr) == win - CW'(1)) begin
        ptr_next = '0;
      end else begin
        ptr_next = ptr + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win  <= WinReset;
      fill <= '0;
      ptr  <= '0;
    end else begin
      if (cfg_wr_en) begin
        win <= win_cfg;
      end
      fill <= fill_next;
      ptr  <= ptr_next;
    end
  end

  // ------------------------------------------------------------ age ring
  logic          ring_we;
  logic [PW-1:0] ring_wa;
  logic [RW-1:0] ring_wd, ring_rd, ring_wd_q, old_word;
  logic          ring_fwd;     // last write hit the entry now being read

  assign ring_we = accept;
  assign ring_wa = full ? ptr : PW'(fill);
  assign ring_wd = {sample_x, sample_y, sample_z};

  tasm_ram #(
    .WIDTH (RW),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_wa),
    .wr_data (ring_wd),
    .rd_addr (ptr_next),
    .rd_data (ring_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_fwd <= 1'b0;
    end else begin
      ring_fwd <= ring_we && (ring_wa == ptr_next);
    end
  end

  always_ff @(posedge clk) begin
    ring_wd_q <= ring_wd;
  end

  assign old_word = ring_fwd ? ring_wd_q : ring_rd;

  // ---------------------------------------------------------- sorted chains
  cell_ctrl_t                    ctrl;
  logic signed [SAMPLE_BITS-1:0] samp [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] old  [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] cval [NUM_AXES][WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] crem [NUM_AXES][WINDOW_MAX];
  logic                          cle  [NUM_AXES][WINDOW_MAX];

  assign ctrl.load = accept;
  assign ctrl.full = full;

  // Axis 0 is x, 1 is y, 2 is z; the ring word packs x in the top bits.
  assign samp[0] = sample_x;
  assign samp[1] = sample_y;
  assign samp[2] = sample_z;
  assign old[0]  = old_word[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
  assign old[1]  = old_word[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign old[2]  = old_word[SAMPLE_BITS-1:0];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] right_val;
      logic signed [SAMPLE_BITS-1:0] left_rem;
      logic                          left_le;

      if (i == WINDOW_MAX - 1) begin : g_last
        assign right_val = cval[a][i];
      end else begin : g_mid
        assign right_val = cval[a][i+1];
      end

      if (i == 0) begin : g_first
        assign left_rem = samp[a];
        assign left_le  = 1'b1;
      end else begin : g_rest
        assign left_rem = crem[a][i-1];
        assign left_le  = cle[a][i-1];
      end

      tasm_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_BITS    (CW),
        .INDEX       (i)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .cnt       (cnt),
        .sample    (samp[a]),
        .old       (old[a]),
        .right_val (right_val),
        .left_rem  (left_rem),
        .left_le   (left_le),
        .val       (cval[a][i]),
        .rem       (crem[a][i]),
        .le        (cle[a][i])
      );
    end
  end

  // ------------------------------------------------------- result pipeline
  // s1: chain holds the result; s2: middle pair picked; out: median.
  logic                          s1_valid, s2_valid;
  logic                          s1_go, s2_go;
  logic [CW-1:0]                 s1_count, s2_count;
  logic [PW-1:0]                 lo_idx, hi_idx;
  logic signed [SAMPLE_BITS-1:0] lo_sel [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] hi_sel [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] s2_lo  [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] s2_hi  [NUM_AXES];
  logic signed [SAMPLE_BITS:0]   pair_sum [NUM_AXES];

  assign s2_go    = !out_valid || !out_stall;
  assign s1_go    = !s2_valid || s2_go;
  assign in_stall = s1_valid && !s1_go;  // chain must hold until picked

  // Odd count: both indexes land on the middle entry.
  assign lo_idx = PW'((s1_count - CW'(1)) >> 1);
  assign hi_idx = PW'(s1_count >> 1);

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      lo_sel[a] = '0;
      hi_sel[a] = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
        if (PW'(i) == lo_idx) begin
          lo_sel[a] = cval[a][i];
        end
        if (PW'(i) == hi_idx) begin
          hi_sel[a] = cval[a][i];
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      pair_sum[a] = {s2_lo[a][SAMPLE_BITS-1], s2_lo[a]}
                  + {s2_hi[a][SAMPLE_BITS-1], s2_hi[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        s2_valid <= s1_valid;
      end
      if (s2_go) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_count <= full ? win : (fill + CW'(1));
    end
    if (s1_go && s1_valid) begin
      s2_count <= s1_count;
      for (int a = 0; a < NUM_AXES; a++) begin
        s2_lo[a] <= lo_sel[a];
        s2_hi[a] <= hi_sel[a];
      end
    end
    if (s2_go && s2_valid) begin
      // Arithmetic halving of the exact sum floors toward minus infinity.
      median_x   <= pair_sum[0][SAMPLE_BITS:1];
      median_y   <= pair_sum[1][SAMPLE_BITS:1];
      median_z   <= pair_sum[2][SAMPLE_BITS:1];
      held_count <= COUNT_OUT_WIDTH'(s2_count);
    end
  end

  // ------------------------------------------------------------ assertions
  `TASM_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= win,
    "fill count exceeds window length")

  `TASM_ASSERT_NEXT(a_fill_step, clk, rst, accept && !full && !cfg_wr_en,
    fill == $past(fill) + CW'(1), "fill count did not advance on a filling transfer")

  `TASM_ASSERT_NOW(a_stall_empty, clk, rst, !s1_valid, !in_stall,
    "input stalled with an empty chain stage")

  `TASM_ASSERT_NOW(a_count_live, clk, rst, out_valid, held_count != '0,
    "result shows an empty window")

endmodule

@@ test/three_axis_sliding_median_tb.sv @@
// Self-checking bench for the three-axis sliding median filter.
// Needs tasm_pkg and the three_axis_sliding_median RTL; reads no files.
// Directed table first, then random phases under varied window lengths.
module three_axis_sliding_median_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tasm_pkg::*;

  localparam int WIN_MAX     = 64;
  localparam int SBITS       = 16;
  localparam int CLK_HALF    = 5;
  localparam int RST_CYCLES  = 8;
  localparam int SETTLE      = 8;     // pipeline is 3 deep plus output buffering
  localparam int LONG_HOLD   = 300;   // receiver hold-off used to back the block up
  localparam int STALL_LIMIT = 3000;  // cycles with no transfer before giving up
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 130;
  localparam int PRINT_CAP   = 100;

  typedef logic signed [SBITS-1:0] sample_t;
  typedef logic [CFG_WIDTH-1:0] win_t;

  localparam sample_t S_MAX = 16'sh7fff;
  localparam sample_t S_MIN = 16'sh8000;

  // one expected median triple plus fill level
  typedef struct packed {
    sample_t                   mx;
    sample_t                   my;
    sample_t                   mz;
    logic [COUNT_OUT_WIDTH-1:0] cnt;
  } median_rec_t;

  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

  // directed stimulus row: either a sample transfer or a window_len write
  typedef struct packed {
    row_kind_t   kind;
    win_t        win;
    sample_t     x;
    sample_t     y;
    sample_t     z;
    logic        typed;  // use the typed-in result instead of the predictor's
    median_rec_t want;
  } dir_row_t;

  localparam median_rec_t NO_WANT = '{16'sd0, 16'sd0, 16'sd0, 7'd0};
  localparam int N_DIR = 28;

  // Window is 8 out of reset. Covers: field extremes, even-count flooring of
  // negative sums, equal samples, window zero read as one, oversize windows
  // saturating to the maximum, a write emptying the window, window of one.
  dir_row_t dir_rows [N_DIR] = '{
    '{ROW_SAMPLE, 7'd0, S_MAX, S_MIN, 16'sd0, 1'b1, '{S_MAX, S_MIN, 16'sd0, 7'd1}},
    '{ROW_SAMPLE, 7'd0, S_MIN, S_MAX, -16'sd1, 1'b1, '{-16'sd1, -16'sd1, -16'sd1, 7'd2}},
    '{ROW_SAMPLE, 7'd0, 16'sd5, 16'sd5, 16'sd5, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 7'd0, 16'sd5, 16'sd5, 16'sd5, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 7'd0, -16'sd1, -16'sd1, -16'sd1, 1'b0, NO_WANT},
    '{ROW_WINDOW, 7'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 7'd0, 16'sd100, -16'sd100, 16'sd7, 1'b1,
      '{16'sd100, -16'sd100, 16'sd7, 7'd1}},
    '{ROW_SAMPLE, 7'd0, S_MIN, S_MAX, S_MIN, 1'b1, '{S_MIN, S_MAX, S_MIN, 7'd1}},
    '{ROW_SAMPLE, 7'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 7'd1}},
    '{ROW_WINDOW, 7'd2, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 7'd0, 16'sd1, 16'sd2, 16'sd3, 1'b1, '{16'sd1, 16'sd2, 16'sd3, 7'd1}},
    '{ROW_SAMPLE, 7'd0, 16'sd4, -16'sd3, 16'sd3, 1'b1, '{16'sd2, -16'sd1, 16'sd3, 7'd2}},
    '{ROW_SAMPLE, 7'd0, -16'sd7, -16'sd7, S_MAX, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 7'd0, -16'sd7, S_MAX, S_MAX, 1'b0, NO_WANT},
    '{ROW_WINDOW, 7'd127, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 7'd0, S_MAX, S_MAX, S_MAX, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 7'd0, S_MIN, S_MIN, S_MIN, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 7'd0, 16'sd3, 16'sd3, 16'sd3, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 7'd0, 16'sd3, -16'sd3, 16'sd3, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 7'd0, 16'sd2, 16'sd2, -16'sd2, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 7'd0, S_MAX, S_MIN, 16'sd0, 1'b0, NO_WANT},
    '{ROW_WINDOW, 7'd65, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 7'd0, -16'sd2, -16'sd3, -16'sd4, 1'b1,
      '{-16'sd2, -16'sd3, -16'sd4, 7'd1}},
    '{ROW_SAMPLE, 7'd0, -16'sd1, -16'sd2, -16'sd3, 1'b1,
      '{-16'sd2, -16'sd3, -16'sd4, 7'd2}},
    '{ROW_SAMPLE, 7'd0, -16'sd1, 16'sd0, 16'sd1, 1'b0, NO_WANT},
    '{ROW_WINDOW, 7'd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 7'd0, 16'sd9, -16'sd9, 16'sd0, 1'b1, '{16'sd9, -16'sd9, 16'sd0, 7'd1}},
    '{ROW_SAMPLE, 7'd0, 16'sd10, -16'sd10, S_MIN, 1'b1,
      '{16'sd10, -16'sd10, S_MIN, 7'd1}}
  };

  logic    clk;
  logic    rst;
  logic    cfg_wr_en;
  win_t    cfg_wr_data;
  logic    in_valid;
  logic    in_stall;
  sample_t sample_x;
  sample_t sample_y;
  sample_t sample_z;
  logic    out_valid;
  logic    out_stall;
  sample_t median_x;
  sample_t median_y;
  sample_t median_z;
  logic [COUNT_OUT_WIDTH-1:0] held_count;

  three_axis_sliding_median #(
    .WINDOW_MAX  (WIN_MAX),
    .SAMPLE_BITS (SBITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_x    (sample_x),
    .sample_y    (sample_y),
    .sample_z    (sample_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .median_x    (median_x),
    .median_y    (median_y),
    .median_z    (median_z),
    .held_count  (held_count)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the filter. Per axis: arrival-order ring and a sorted list.
  // ---------------------------------------------------------------------------
  sample_t     arrival [3][WIN_MAX];
  sample_t     ranked  [3][WIN_MAX];
  int unsigned held_n;
  int unsigned oldest_idx;
  win_t        win_reg;

  median_rec_t pending_medians [$];  // results owed by the block, oldest first
  int          mismatch_count;

  // idle mix, changed per phase
  int          send_gap_pct;
  int          recv_stall_pct;
  bit          hold_request;

  // Advance the shadow filter by one sample transfer and return its result.
  // When full, the oldest sample leaves (first equal sorted entry goes),
  // then the new one goes in after any equal entries.
  function automatic median_rec_t predict_medians(sample_t x, sample_t y, sample_t z);
    sample_t     in_s [3];
    sample_t     med  [3];
    sample_t     old_v;
    int unsigned w, slot, i, pos, n;
    int          pair;
    int          a;
    median_rec_t rec;
    w = (win_reg == 0) ? 1 : ((win_reg > WIN_MAX) ? WIN_MAX : win_reg);
    in_s[0] = x;
    in_s[1] = y;
    in_s[2] = z;
    for (a = 0; a < 3; a++) begin
      if (held_n < w) begin
        arrival[a][held_n] = in_s[a];
        n = held_n;
      end else begin
        slot = oldest_idx % w;
        old_v = arrival[a][slot];
        arrival[a][slot] = in_s[a];
        i = 0;
        while (i < w && ranked[a][i] != old_v) i++;
        for (; i + 1 < w; i++) ranked[a][i] = ranked[a][i+1];
        n = w - 1;
      end
      pos = 0;
      while (pos < n && ranked[a][pos] <= in_s[a]) pos++;
      for (i = n; i > pos; i--) ranked[a][i] = ranked[a][i-1];
      ranked[a][pos] = in_s[a];
    end
    if (held_n < w) begin
      held_n++;
    end else begin
      oldest_idx = (oldest_idx % w + 1) % w;
    end
    n = held_n;
    for (a = 0; a < 3; a++) begin
      if (n % 2 == 1) begin
        med[a] = ranked[a][n/2];
      end else begin
        // exact sum, arithmetic shift floors toward minus infinity
        pair = int'(ranked[a][n/2]) + int'(ranked[a][n/2-1]);
        med[a] = sample_t'(pair >>> 1);
      end
    end
    rec.mx  = med[0];
    rec.my  = med[1];
    rec.mz  = med[2];
    rec.cnt = COUNT_OUT_WIDTH'(n);
    return rec;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return sample_t'($urandom);
      5, 6, 7:       return sample_t'(int'($urandom_range(0, 8)) - 4);  // many ties
      8:             return $urandom_range(0, 1) ? S_MAX : S_MIN;
      default:       return $urandom_range(0, 1) ? sample_t'(0) : sample_t'(-1);
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatch_count < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender side. Entered and left at a falling edge; valid stays high across
  // back-to-back transfers and only drops for a gap or a drain.
  // ---------------------------------------------------------------------------
  task automatic offer_sample(sample_t x, sample_t y, sample_t z, logic typed,
                              median_rec_t typed_rec);
    median_rec_t want;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample_x = x;
    sample_y = y;
    sample_z = z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken at this edge
    want = predict_medians(x, y, z);
    if (typed) want = typed_rec;
    pending_medians.push_back(want);
    @(negedge clk);
  endtask

  // Stop offering and wait for every owed result, then let the pipe settle.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // window_len write; only done with the block empty. It also empties the window.
  task automatic set_window(win_t len);
    drain_results();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = len;
    @(negedge clk);
    cfg_wr_en  = 1'b0;
    win_reg    = len;
    held_n     = 0;
    oldest_idx = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long counted hold-off when asked for one.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every output transfer against the oldest owed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    median_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_medians.size() == 0) begin
        flag_mismatch($sformatf("result with none owed: x=%0d y=%0d z=%0d n=%0d",
                                median_x, median_y, median_z, held_count));
      end else begin
        want = pending_medians.pop_front();
        if (median_x !== want.mx)
          flag_mismatch($sformatf("median_x %0d, want %0d", median_x, want.mx));
        if (median_y !== want.my)
          flag_mismatch($sformatf("median_y %0d, want %0d", median_y, want.my));
        if (median_z !== want.mz)
          flag_mismatch($sformatf("median_z %0d, want %0d", median_z, want.mz));
        if (held_count !== want.cnt)
          flag_mismatch($sformatf("held_count %0d, want %0d", held_count, want.cnt));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transfer on either side ends the run.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    win_t phase_len [PHASES];
    int   r, ph, k;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    sample_x       = '0;
    sample_y       = '0;
    sample_z       = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    mismatch_count = 0;
    win_reg        = win_t'(WIN_RESET);
    held_n         = 0;
    oldest_idx     = 0;

    repeat (RST_CYCLES) @(negedge clk);
    rst = 1'b0;

    // directed table, no idling
    for (r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].kind == ROW_WINDOW) begin
        set_window(dir_rows[r].win);
      end else begin
        offer_sample(dir_rows[r].x, dir_rows[r].y, dir_rows[r].z,
                     dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // random phases: largest window, window of one, small, zero, oversize, mid
    phase_len[0] = win_t'(WIN_MAX);
    phase_len[1] = 7'd1;
    phase_len[2] = win_t'($urandom_range(2, 9));
    phase_len[3] = 7'd0;
    phase_len[4] = 7'd100;
    phase_len[5] = win_t'($urandom_range(10, WIN_MAX - 1));

    for (ph = 0; ph < PHASES; ph++) begin
      set_window(phase_len[ph]);
      // sender-light/receiver-heavy, then swapped, then flat out
      if (ph < 2) begin
        send_gap_pct   = 28;
        recv_stall_pct = 75;
      end else if (ph < 4) begin
        send_gap_pct   = 75;
        recv_stall_pct = 28;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // a full stop mid-stream with the window kept
        if (ph == 0 && k == PHASE_ITEMS / 2) drain_results();
        // back the block up until it stalls its input
        if ((ph == 1 || ph == 4) && k == 30) hold_request = 1'b1;
        offer_sample(pick_sample(), pick_sample(), pick_sample(), 1'b0, NO_WANT);
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && pending_medians.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
